// ----- src/pbr_pkg.sv -----
// Package: shared types and constants of the PE base relocation parser.
package pbr_pkg;

	typedef enum logic [1:0] {
		EV_RELOC = 2'd0,
		EV_END   = 2'd1,
		EV_ZERO  = 2'd2,
		EV_BAD   = 2'd3
	} event_t;

	typedef enum logic {
		CFG_DIR_SIZE   = 1'b0,
		CFG_IMAGE_BASE = 1'b1
	} cfg_reg_t;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned OUT_DATA_W = 104;

	typedef struct packed {
		logic        valid;
		event_t      ev;
		logic [31:0] rva;
		logic [3:0]  rtype;
		logic [63:0] va;
	} result_t;

endpackage

// ----- src/pbr_core.sv -----
// Module: relocation directory walk state and per-byte result generation.
module pbr_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       directory_size,
	input  logic [63:0]       image_base,
	output pbr_pkg::result_t  res
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LOW,
		PH_HIGH,
		PH_DONE
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] page_q, page_d;
	logic [31:0] len_q, len_d;
	logic [31:0] consumed_q, consumed_d;
	logic [7:0]  low_q, low_d;

	logic [2:0]  hdr_idx;
	logic [31:0] len_new;
	logic [32:0] cons_sum;
	logic [32:0] pos_inc;
	logic [31:0] entries_end;
	logic [15:0] entry;
	logic [31:0] rva;

	assign hdr_idx     = pos_q[2:0];
	assign cons_sum    = {1'b0, consumed_q} + {1'b0, len_new};
	assign pos_inc     = {1'b0, pos_q} + 33'd1;
	assign entries_end = {len_q[31:1], 1'b0};
	assign entry       = {data_byte, low_q};
	assign rva         = page_q + {20'd0, entry[11:0]};

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		page_d     = page_q;
		len_d      = len_q;
		consumed_d = consumed_q;
		low_d      = low_q;
		len_new    = len_q;
		res        = '0;
		res.ev     = pbr_pkg::EV_RELOC;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_idx == 3'd0 && consumed_q >= directory_size) begin
					phase_d   = PH_DONE;
					res.valid = 1'b1;
					res.ev    = pbr_pkg::EV_END;
				end else begin
					case (hdr_idx)
						3'd0: page_d = {24'd0, data_byte};
						3'd1: page_d = {page_q[31:16], data_byte, page_q[7:0]};
						3'd2: page_d = {page_q[31:24], data_byte, page_q[15:0]};
						3'd3: page_d = {data_byte, page_q[23:0]};
						3'd4: len_d = {24'd0, data_byte};
						3'd5: len_d = {len_q[31:16], data_byte, len_q[7:0]};
						3'd6: len_d = {len_q[31:24], data_byte, len_q[15:0]};
						default: len_d = {data_byte, len_q[23:0]};
					endcase
					len_new = len_d;
					pos_d   = {29'd0, hdr_idx} + 32'd1;
					if (hdr_idx == 3'd7) begin
						if (len_d == 32'd0) begin
							phase_d   = PH_DONE;
							res.valid = 1'b1;
							res.ev    = pbr_pkg::EV_ZERO;
						end else if (len_d < 32'd8) begin
							phase_d   = PH_DONE;
							res.valid = 1'b1;
							res.ev    = pbr_pkg::EV_BAD;
						end else begin
							consumed_d = cons_sum[32] ? 32'hFFFF_FFFF : cons_sum[31:0];
							if (len_d == 32'd8) begin
								pos_d = 32'd0;
							end else begin
								phase_d = PH_LOW;
							end
						end
					end
				end
			end
			PH_LOW, PH_HIGH: begin
				if (pos_q < entries_end) begin
					if (phase_q == PH_LOW) begin
						low_d   = data_byte;
						phase_d = PH_HIGH;
					end else begin
						phase_d = PH_LOW;
						if (entry[15:12] != 4'd0) begin
							res.valid = 1'b1;
							res.rva   = rva;
							res.rtype = entry[15:12];
							res.va    = image_base + {32'd0, rva};
						end
					end
				end
				if (pos_inc >= {1'b0, len_q}) begin
					phase_d = PH_HEADER;
					pos_d   = 32'd0;
				end else begin
					pos_d = pos_inc[31:0];
				end
			end
			default: begin
			end
		endcase
		if (!step) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			page_q     <= '0;
			len_q      <= '0;
			consumed_q <= '0;
			low_q      <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			page_q     <= page_d;
			len_q      <= len_d;
			consumed_q <= consumed_d;
			low_q      <= low_d;
		end
	end

endmodule

// ----- src/pe_base_reloc_parser_unit.sv -----
// Top level: PE base relocation table parser with stream ports and config port.
// Usage:
//   s_axis carries the relocation directory one byte per word, in file order.
//   m_axis carries one word per relocation (type not absolute) and one final
//   word for table end, zero-size block or malformed block size.
//   Write directory_size (index 0) and image_base (index 1) through cfg_we /
//   cfg_index / cfg_data while the block is idle; other indexes are ignored.
// Timing:
//   One byte per clock sustained while the output register is free or m_axis_tready
//   is high. A byte is held in the input register, is parsed there in one pass,
//   and its result (if any) is registered in the output register that drives
//   m_axis_tvalid. The 64-bit virtual address add after the 32-bit RVA add sets the path length.
// Reset:
//   arst_n clears the walk to the first header byte and both registers to zero.
// Stall:
//   With m_axis_tready low and a result waiting, one more byte is held in the
//   input register; s_axis_tready drops only when both are full. After the
//   final event every byte is accepted and dropped until reset.
module pe_base_reloc_parser_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [1:0] event_res, [33:2] reloc_rva, [37:34] reloc_type,
	// [101:38] virtual_address, [103:102] zero
	output logic [pbr_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [pbr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pbr_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [31:0]      dir_size_q;
	logic [63:0]      image_base_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	pbr_pkg::result_t res;
	logic             out_valid_q;
	pbr_pkg::event_t  out_ev_q;
	logic [31:0]      out_rva_q;
	logic [3:0]       out_type_q;
	logic [63:0]      out_va_q;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_size_q   <= '0;
			image_base_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == {1'b0, pbr_pkg::CFG_DIR_SIZE}) begin
				dir_size_q <= cfg_data[31:0];
			end else if (cfg_index == {1'b0, pbr_pkg::CFG_IMAGE_BASE}) begin
				image_base_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	pbr_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.data_byte      (byte_s1),
		.directory_size (dir_size_q),
		.image_base     (image_base_q),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_ev_q   <= res.ev;
			out_rva_q  <= res.rva;
			out_type_q <= res.rtype;
			out_va_q   <= res.va;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_va_q, out_type_q, out_rva_q, out_ev_q};

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register overwritten while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !out_valid_q || m_axis_tready)
		else $error("result produced while output register blocked");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_ev_q == pbr_pkg::EV_RELOC |-> out_type_q != 4'd0)
		else $error("relocation word with absolute type");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_ev_q != pbr_pkg::EV_RELOC |->
			out_type_q == 4'd0 && out_rva_q == 32'd0 && out_va_q == 64'd0)
		else $error("stop word carries nonzero payload");

endmodule

// ----- tb/pe_base_reloc_parser_unit_tb.sv -----
// Testbench for the base relocation parser: byte stream in, words checked against a local walk.
`timescale 1ns / 100ps

module pe_base_reloc_parser_unit_tb;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam logic [pbr_pkg::CFG_IDX_W-1:0] CFG_IDX_DIR = {1'b0, pbr_pkg::CFG_DIR_SIZE};
	localparam logic [pbr_pkg::CFG_IDX_W-1:0] CFG_IDX_BASE = {1'b0, pbr_pkg::CFG_IMAGE_BASE};
	localparam logic [pbr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
	localparam logic [pbr_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

	typedef enum logic [1:0] {
		STG_HEADER,
		STG_LOW,
		STG_HIGH
	} walk_stage_t;

	typedef struct packed {
		pbr_pkg::event_t ev;
		logic [31:0]     rva;
		logic [3:0]      rtype;
		logic [63:0]     va;
	} walk_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [7:0]                     s_axis_tdata;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [pbr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                           cfg_we;
	logic [pbr_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pbr_pkg::CFG_DATA_W-1:0] cfg_data;

	// register copies and walk state
	logic [31:0]  dir_size_cfg;
	logic [63:0]  img_base_cfg;
	walk_stage_t  stage;
	logic [31:0]  blk_pos;
	logic [31:0]  page_base;
	logic [31:0]  blk_len;
	logic [31:0]  dir_used;
	logic [7:0]   lo_byte;
	logic         walk_done;

	walk_result_t pending_results[$];

	int unsigned     src_idle_pct;
	int unsigned     sink_stall_pct;
	logic            sink_hold;
	event            hold_go;
	int unsigned     cycle_count = 0;
	int unsigned     fail_count;
	int unsigned     bytes_sent;
	int unsigned     relocs_seen;
	pbr_pkg::event_t last_stop;
	logic            stop_seen;

	pe_base_reloc_parser_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	task automatic finish_walk(input pbr_pkg::event_t ev);
		walk_result_t r;
		r = '0;
		r.ev = ev;
		walk_done = 1'b1;
		pending_results = {pending_results, r};
	endtask

	// advance the walk by one accepted byte
	task automatic walk_byte(input logic [7:0] b);
		walk_result_t r;
		int unsigned  i;
		logic [15:0]  ent;
		logic [32:0]  sum;
		logic [32:0]  pos;
		logic [32:0]  ent_end;
		if (walk_done)
			return;
		if (stage == STG_HEADER) begin
			i = blk_pos & 32'd7;
			if (i == 0 && dir_used >= dir_size_cfg) begin
				finish_walk(pbr_pkg::EV_END);
				return;
			end
			if (i == 0) begin
				page_base = '0;
				blk_len = '0;
			end
			if (i < 4)
				page_base[8*i +: 8] = b;
			else
				blk_len[8*(i-4) +: 8] = b;
			blk_pos = i + 1;
			if (i < 7)
				return;
			if (blk_len == 0) begin
				finish_walk(pbr_pkg::EV_ZERO);
				return;
			end
			if (blk_len < 8) begin
				finish_walk(pbr_pkg::EV_BAD);
				return;
			end
			sum = {1'b0, dir_used} + {1'b0, blk_len};
			dir_used = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			if (blk_len == 8)
				blk_pos = '0;
			else
				stage = STG_LOW;
			return;
		end
		pos = {1'b0, blk_pos};
		ent_end = 33'd8 + (({1'b0, blk_len} - 33'd8) & ~33'd1);
		if (pos < ent_end) begin
			if (stage == STG_LOW) begin
				lo_byte = b;
				stage = STG_HIGH;
			end else begin
				ent = {b, lo_byte};
				stage = STG_LOW;
				if (ent[15:12] != 4'd0) begin
					r.ev = pbr_pkg::EV_RELOC;
					r.rva = page_base + {20'd0, ent[11:0]};
					r.rtype = ent[15:12];
					r.va = img_base_cfg + {32'd0, r.rva};
					pending_results = {pending_results, r};
				end
			end
		end
		pos = pos + 33'd1;
		if (pos >= {1'b0, blk_len}) begin
			stage = STG_HEADER;
			blk_pos = '0;
		end else begin
			blk_pos = pos[31:0];
		end
	endtask

	task automatic check_word(input logic [pbr_pkg::OUT_DATA_W-1:0] d);
		walk_result_t want;
		if (pending_results.size() == 0) begin
			note_failure($sformatf("unexpected word: ev=%0d rva=%h type=%h va=%h",
				d[1:0], d[33:2], d[37:34], d[101:38]));
			return;
		end
		want = pending_results.pop_front();
		if (d[1:0] == pbr_pkg::EV_RELOC)
			relocs_seen++;
		else begin
			stop_seen = 1'b1;
			last_stop = pbr_pkg::event_t'(d[1:0]);
		end
		if (d[1:0] !== want.ev || d[33:2] !== want.rva || d[37:34] !== want.rtype ||
			d[101:38] !== want.va)
			note_failure($sformatf({"mismatch: expected ev=%0d rva=%h type=%h va=%h, ",
				"got ev=%0d rva=%h type=%h va=%h"}, want.ev, want.rva, want.rtype, want.va,
				d[1:0], d[33:2], d[37:34], d[101:38]));
	endtask

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			check_word(m_axis_tdata);
		m_axis_tready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
	end

	// long output hold-off, own cycle count
	initial begin
		sink_hold = 1'b0;
		forever begin
			@(hold_go);
			sink_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			sink_hold <= 1'b0;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		bytes_sent++;
		walk_byte(b);
	endtask

	task automatic send_header(input logic [31:0] page, input logic [31:0] len);
		int unsigned k;
		for (k = 0; k < 4; k++)
			send_byte(page[8*k +: 8]);
		for (k = 0; k < 4; k++)
			send_byte(len[8*k +: 8]);
	endtask

	task automatic send_block(input logic [31:0] page, input logic [31:0] len,
		input int unsigned zero_pct);
		int unsigned k;
		logic [15:0] ent;
		send_header(page, len);
		for (k = 8; k + 1 < len; k += 2) begin
			ent[15:12] = ($urandom_range(99) < zero_pct) ? 4'd0 : 4'($urandom_range(15, 1));
			ent[11:0] = 12'($urandom_range(4095));
			send_byte(ent[7:0]);
			send_byte(ent[15:8]);
		end
		if (len[0])
			send_byte(8'($urandom_range(255)));
	endtask

	// drop valid, wait for all words, then let the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pbr_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_DIR)
			dir_size_cfg = v[31:0];
		else if (idx == CFG_IDX_BASE)
			img_base_cfg = v;
		@(posedge clk);
	endtask

	// wrapping rva and address, absolute entry, odd tail byte, empty block
	task automatic test_directed_entries();
		write_reg(CFG_IDX_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
		src_idle_pct = 0;
		sink_stall_pct <= 0;
		send_header(32'hFFFF_FFFF, 32'd15);
		send_byte(8'hFF);
		send_byte(8'hAF);
		send_byte(8'h23);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hF0);
		send_byte(8'h5A);
		send_header(32'h0000_0000, 32'd8);
		settle();
	endtask

	task automatic test_output_backpressure();
		write_reg(CFG_IDX_BASE, 64'h0000_0000_0040_0000);
		src_idle_pct = 0;
		sink_stall_pct <= 0;
		-> hold_go;
		send_block($urandom, 32'd8 + 32'd2 * 32'd48, 0);
		settle();
	endtask

	task automatic test_random_walk(input int unsigned src_pct, input int unsigned sink_pct,
		input int unsigned n_bytes, input logic [63:0] base);
		int unsigned start;
		logic [31:0] page;
		logic [31:0] len;
		write_reg(CFG_IDX_BASE, base);
		src_idle_pct = src_pct;
		sink_stall_pct <= sink_pct;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			case ($urandom_range(7))
				0: page = 32'h0000_0000;
				1: page = 32'hFFFF_FFFF;
				default: page = $urandom;
			endcase
			if ($urandom_range(9) == 0)
				len = 32'd8 + 32'($urandom_range(160, 60));
			else
				len = 32'd8 + 32'($urandom_range(30));
			send_block(page, len, 20);
		end
		settle();
	endtask

	// writes to unused indexes must leave both registers alone
	task automatic test_ignored_indexes();
		write_reg(CFG_IDX_DIR, {32'd0, dir_used + 32'd50000});
		write_reg(CFG_IDX_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(CFG_IDX_SPARE_HI, 64'h0000_0000_0000_0000);
	endtask

	// one terminal condition per run, then bytes that must be dropped
	task automatic test_walk_stop();
		int unsigned k;
		src_idle_pct = 34;
		sink_stall_pct <= 34;
		case ($urandom_range(3))
			0: begin
				// next header starts inside the directory and runs past its end
				write_reg(CFG_IDX_DIR, {32'd0, dir_used + 32'($urandom_range(7, 1))});
				send_block($urandom, 32'd8 + 32'd2 * 32'($urandom_range(4, 1)), 0);
				send_byte(8'($urandom_range(255)));
			end
			1: begin
				write_reg(CFG_IDX_DIR, 64'd0);
				send_byte(8'($urandom_range(255)));
			end
			2: send_header($urandom, 32'd0);
			default: send_header($urandom, 32'($urandom_range(7, 1)));
		endcase
		for (k = 0; k < 12; k++)
			send_byte(8'($urandom_range(255)));
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		bytes_sent = 0;
		relocs_seen = 0;
		stop_seen = 1'b0;
		last_stop = pbr_pkg::EV_RELOC;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		dir_size_cfg = '0;
		img_base_cfg = '0;
		stage = STG_HEADER;
		blk_pos = '0;
		page_base = '0;
		blk_len = '0;
		dir_used = '0;
		lo_byte = '0;
		walk_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_IDX_DIR, 64'h0000_0000_FFFF_FFFF);
		test_directed_entries();
		test_output_backpressure();
		test_random_walk(0, 0, 160, 64'h0000_0000_0000_0000);
		test_ignored_indexes();
		test_random_walk(67, 0, 160, {$urandom, $urandom});
		test_random_walk(0, 67, 160, 64'h8000_0000_0000_0000);
		test_random_walk(34, 34, 160, {$urandom, $urandom});
		test_walk_stop();

		if (pending_results.size() != 0)
			note_failure($sformatf("%0d words never arrived", pending_results.size()));
		$display("sent %0d directory bytes over idle mixes 0/0, 67/0, 0/67, 34/34",
			bytes_sent);
		$display("with a %0d-cycle output hold; checked %0d relocations, stop by %s, %0d failures",
			HOLD_CYCLES, relocs_seen, stop_seen ? last_stop.name() : "nothing", fail_count);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- pe_base_reloc_parser_unit.f -----
src/pbr_pkg.sv
src/pbr_core.sv
src/pe_base_reloc_parser_unit.sv
tb/pe_base_reloc_parser_unit_tb.sv
